// ===== rtl/core/mpfg_pkg.sv =====
package mpfg_pkg;

	localparam int IDX_W        = 6;
	localparam int ROM_SLOTS    = 1 << IDX_W;
	localparam int ROM_USED     = 33;
	localparam int POLL_ENTRIES = 33;

	localparam logic [15:0] POLL_DELAY_RST   = 16'd1000;
	localparam logic [31:0] REBOOT_LIMIT_RST = 32'd600000;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  SLAVE_ID  = 8'h01;
	localparam logic [7:0]  FUNC_READ = 8'h03;

	// Configuration register indexes
	localparam logic REG_POLL_DELAY   = 1'b0;
	localparam logic REG_REBOOT_LIMIT = 1'b1;

	// Poll table entries: page, offset, register count
	localparam logic [23:0] POLL_TABLE [ROM_USED] = '{
		24'h000A12, 24'h002408, 24'h004614, 24'h00560E, 24'h006E20, 24'h00C901,
		24'h0BB910, 24'h0BD703, 24'h0BDA05, 24'h0BDF11, 24'h0BF101, 24'h0BF201,
		24'h0BF301, 24'h0BF401, 24'h0BF501, 24'h041030, 24'h0D0001, 24'h0D4001,
		24'h0D8001, 24'h0DC001, 24'h0E0001, 24'h0E4001, 24'h0E8001, 24'h0EC001,
		24'h0F0001, 24'h0F4001, 24'h0F8001, 24'h0FC001, 24'h0B0001, 24'h0B4001,
		24'h0B8001, 24'h0BC001, 24'h030A10
	};

	typedef struct packed {
		logic       reboot;
		logic [7:0] page;
		logic [7:0] offset;
		logic [7:0] count;
		logic [7:0] crc_lo;
		logic [7:0] crc_hi;
	} job_t;

	// ROM word: page, offset, count, CRC low, CRC high
	typedef logic [39:0] rom_word_t;
	typedef rom_word_t rom_t [ROM_SLOTS];

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

	// The frame CRC depends only on the entry, so fold it into the ROM
	function automatic rom_t build_rom();
		rom_t        r;
		logic [23:0] entry;
		logic [15:0] crc;
		for (int i = 0; i < ROM_SLOTS; i++) begin
			entry = (i < ROM_USED) ? POLL_TABLE[i] : 24'h000000;
			crc   = CRC_INIT;
			crc   = crc_byte(crc, SLAVE_ID);
			crc   = crc_byte(crc, FUNC_READ);
			crc   = crc_byte(crc, entry[23:16]);
			crc   = crc_byte(crc, entry[15:8]);
			crc   = crc_byte(crc, 8'h00);
			crc   = crc_byte(crc, entry[7:0]);
			r[i]  = {entry, crc[7:0], crc[15:8]};
		end
		return r;
	endfunction

	localparam rom_t POLL_ROM = build_rom();

endpackage

// ===== rtl/core/modbus_poll_frame_generator.sv =====
// Modbus poll frame generator.
// Input channel (in_valid / in_stall / link_up): one transaction per
// millisecond tick. Output channel (out_valid / out_stall / frame_byte,
// last_byte, reboot_request): results of each tick, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is
// always ready; index 0 is the poll delay, index 1 the reboot limit.
// When a tick is taken, the tick count and the table index update at the
// accepting edge, and the poll entry with its precomputed CRC is read from
// a constant ROM into a job slot. Results come from the registered current
// slot. A poll tick gives eight frame bytes, one per cycle while out_stall
// is low; a reboot tick gives one result and an idle tick none. A second
// job slot holds one more tick's job while the current one drains, so
// in_stall rises only when both slots are full. While out_stall is high
// the presented byte holds. Reset clears the tick count, the table index
// and both job slots and restores register defaults.
module modbus_poll_frame_generator #(
	parameter int POLL_ENTRIES = mpfg_pkg::POLL_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        link_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        last_byte,
	output logic        reboot_request,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import mpfg_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POLL_ENTRIES - 1);

	logic [15:0]      poll_delay_q;
	logic [31:0]      reboot_limit_q;
	logic [31:0]      elapsed_q;
	logic [IDX_W-1:0] poll_index_q;

	job_t             cur_q;
	logic             cur_valid_q;
	logic [2:0]       byte_cnt_q;
	job_t             pend_q;
	logic             pend_valid_q;

	logic [31:0]      elapsed_next;
	logic             in_accept;
	logic             reboot_hit;
	logic             poll_hit;
	logic             job_new;
	job_t             new_job;
	rom_word_t        rom_word;
	logic             cur_last;
	logic             out_take;
	logic             cur_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_delay_q   <= POLL_DELAY_RST;
			reboot_limit_q <= REBOOT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLL_DELAY:   poll_delay_q   <= cfg_data[15:0];
				REG_REBOOT_LIMIT: reboot_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = pend_valid_q;
	assign in_accept = in_valid && !in_stall;

	// Saturating tick count, then reboot check ahead of the poll check
	assign elapsed_next = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
	assign reboot_hit   = elapsed_next > reboot_limit_q;
	assign poll_hit     = !reboot_hit && link_up && (elapsed_next > {16'h0000, poll_delay_q});
	assign job_new      = in_accept && (reboot_hit || poll_hit);

	assign rom_word = POLL_ROM[poll_index_q];

	always_comb begin
		new_job        = '0;
		new_job.reboot = reboot_hit;
		if (!reboot_hit) begin
			{new_job.page, new_job.offset, new_job.count, new_job.crc_lo, new_job.crc_hi} =
				rom_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			poll_index_q <= '0;
		end else if (in_accept) begin
			elapsed_q <= poll_hit ? 32'd0 : elapsed_next;
			if (poll_hit) begin
				poll_index_q <= (poll_index_q >= LAST_IDX) ? '0 : poll_index_q + 1'b1;
			end
		end
	end

	assign cur_last = cur_q.reboot || (byte_cnt_q == 3'd7);
	assign out_take = cur_valid_q && !out_stall;
	assign cur_done = out_take && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			byte_cnt_q   <= '0;
		end else begin
			if (!cur_valid_q || cur_done) begin
				byte_cnt_q <= '0;
				if (pend_valid_q) begin
					cur_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					cur_valid_q <= job_new;
				end
			end else begin
				if (out_take) begin
					byte_cnt_q <= byte_cnt_q + 3'd1;
				end
				if (job_new) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cur_valid_q || cur_done) begin
			cur_q <= pend_valid_q ? pend_q : new_job;
		end else if (job_new) begin
			pend_q <= new_job;
		end
	end

	// Byte select in wire order
	always_comb begin
		case (byte_cnt_q)
			3'd0:    frame_byte = SLAVE_ID;
			3'd1:    frame_byte = FUNC_READ;
			3'd2:    frame_byte = cur_q.page;
			3'd3:    frame_byte = cur_q.offset;
			3'd4:    frame_byte = 8'h00;
			3'd5:    frame_byte = cur_q.count;
			3'd6:    frame_byte = cur_q.crc_lo;
			3'd7:    frame_byte = cur_q.crc_hi;
			default: frame_byte = 8'h00;
		endcase
		if (cur_q.reboot) begin
			frame_byte = 8'h00;
		end
	end

	assign out_valid      = cur_valid_q;
	assign last_byte      = cur_last;
	assign reboot_request = cur_q.reboot;

	a_pend_behind_cur: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> cur_valid_q)
		else $error("pending job without a current job");

	a_reboot_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reboot_request) |-> (last_byte && byte_cnt_q == 3'd0))
		else $error("reboot result not a single result");

	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && poll_hit) |=> (elapsed_q == 32'd0))
		else $error("tick count not cleared after poll");

	a_byte_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !cur_last) |=> (cur_valid_q && byte_cnt_q == 3'($past(byte_cnt_q) + 3'd1)))
		else $error("frame byte did not advance");

endmodule
